/* design/wsd_pkg.sv */
// Shared constants for the websocket frame deframer: field widths,
// length codes and the bit layout of the result stream sideband.
// No dependencies.
`default_nettype none

package wsd_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned LEN_W  = 63;
	localparam int unsigned KEY_W  = 32;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

	localparam logic [LEN_W-1:0] MAX_SIZE_RST = LEN_W'(65535);

	localparam int unsigned OUT_TDATA_W = 72;
	localparam int unsigned OUT_TUSER_W = 9;

	localparam int unsigned TU_PV     = 0;
	localparam int unsigned TU_START  = 1;
	localparam int unsigned TU_OPC_LO = 2;
	localparam int unsigned TU_FIN    = 6;
	localparam int unsigned TU_MASK   = 7;
	localparam int unsigned TU_ERR    = 8;

	localparam int unsigned TD_LEN_LO = 8;

endpackage

`default_nettype wire

/* design/websocket_frame_deframer.sv */
// Output: each accepted byte's result is registered and shows in the cycle after it is accepted.
// Throughput: one byte per cycle while the result side takes every result;
// the single output register frees in the cycle it is taken.
// Reset: parser awaits the first header byte, all frame state zero,
// no error latched, max_message_size 65535, output empty.
// Header parse, length check and unmasking run in one pass per byte.
`default_nettype none

module websocket_frame_deframer import wsd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [DATA_W-1:0]      s_axis_tdata,   // [7:0] data_byte
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [7:0] payload_byte, [70:8] frame_length, [71] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// [0] payload_valid, [1] frame_start, [5:2] frame_opcode,
	// [6] final_flag, [7] masked_flag, [8] error_code
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
	output logic                        m_axis_tlast,   // frame_end
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [LEN_W-1:0]       cfg_data        // max_message_size
);

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_ERROR
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [3:0]          cnt_q, cnt_n;
	logic [LEN_W-1:0]    acc_q, acc_n;
	logic [KEY_W-1:0]    key_q, key_n;
	logic [LEN_W-1:0]    rem_q, rem_n;
	logic [1:0]          mph_q, mph_n;
	logic                fin_q, fin_n;
	logic [3:0]          opc_q, opc_n;
	logic                msk_q, msk_n;
	logic                err_q, err_n;
	logic                ovf_q, ovf_n;
	logic [LEN_W-1:0]    max_q;

	logic                in_acc;
	logic                len_done;
	logic                hdr_done;
	logic                pv, st, en;
	logic [DATA_W-1:0]   pb;
	logic [6:0]          code;
	logic [LEN_W-1:0]    rem_dec;

	logic                out_valid_q;
	logic [DATA_W-1:0]   pb_q;
	logic [LEN_W-1:0]    len_q;
	logic                pv_q, st_q, en_q, out_fin_q, out_msk_q, out_err_q;
	logic [3:0]          out_opc_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign code          = s_axis_tdata[6:0];
	assign rem_dec       = rem_q - LEN_W'(1);

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		key_n    = key_q;
		rem_n    = rem_q;
		mph_n    = mph_q;
		fin_n    = fin_q;
		opc_n    = opc_q;
		msk_n    = msk_q;
		err_n    = err_q;
		ovf_n    = ovf_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		pv       = 1'b0;
		st       = 1'b0;
		en       = 1'b0;
		pb       = '0;
		unique case (phase_q)
			PH_HDR1: begin
				msk_n = s_axis_tdata[7];
				ovf_n = 1'b0;
				acc_n = '0;
				cnt_n = '0;
				if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
					cnt_n   = (code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
					phase_n = PH_EXTLEN;
				end else begin
					acc_n    = LEN_W'(code);
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				ovf_n = ovf_q || (acc_q[LEN_W-1 -: DATA_W] != '0);
				acc_n = ovf_n ? '1 : {acc_q[LEN_W-DATA_W-1:0], s_axis_tdata};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == '0) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_n[{cnt_q[1:0], 3'b000} +: DATA_W] =
					key_q[{cnt_q[1:0], 3'b000} +: DATA_W] | s_axis_tdata;
				cnt_n = cnt_q + 4'd1;
				if (cnt_n >= KEY_BYTES) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				pv    = 1'b1;
				pb    = s_axis_tdata ^
					(msk_q ? key_q[{mph_q, 3'b000} +: DATA_W] : '0);
				mph_n = mph_q + 2'd1;
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					en      = 1'b1;
					phase_n = PH_HDR0;
				end
			end
			PH_ERROR: begin
			end
			default: begin
				fin_n   = s_axis_tdata[7];
				opc_n   = s_axis_tdata[3:0];
				msk_n   = 1'b0;
				acc_n   = '0;
				ovf_n   = 1'b0;
				rem_n   = '0;
				key_n   = '0;
				mph_n   = '0;
				cnt_n   = '0;
				phase_n = PH_HDR1;
			end
		endcase

		if (len_done) begin
			if (ovf_n || acc_n > max_q) begin
				err_n   = 1'b1;
				phase_n = PH_ERROR;
			end else begin
				rem_n = acc_n;
				key_n = '0;
				if (msk_n) begin
					cnt_n   = '0;
					phase_n = PH_KEY;
				end else begin
					hdr_done = 1'b1;
				end
			end
		end

		if (hdr_done) begin
			st    = 1'b1;
			mph_n = '0;
			if (rem_n == '0) begin
				en      = 1'b1;
				phase_n = PH_HDR0;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			cnt_q       <= '0;
			acc_q       <= '0;
			key_q       <= '0;
			rem_q       <= '0;
			mph_q       <= '0;
			fin_q       <= 1'b0;
			opc_q       <= '0;
			msk_q       <= 1'b0;
			err_q       <= 1'b0;
			ovf_q       <= 1'b0;
			max_q       <= MAX_SIZE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (in_acc) begin
				phase_q     <= phase_n;
				cnt_q       <= cnt_n;
				acc_q       <= acc_n;
				key_q       <= key_n;
				rem_q       <= rem_n;
				mph_q       <= mph_n;
				fin_q       <= fin_n;
				opc_q       <= opc_n;
				msk_q       <= msk_n;
				err_q       <= err_n;
				ovf_q       <= ovf_n;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pb_q      <= pb;
			len_q     <= acc_n;
			pv_q      <= pv;
			st_q      <= st;
			en_q      <= en;
			out_fin_q <= fin_n;
			out_msk_q <= msk_n;
			out_opc_q <= opc_n;
			out_err_q <= err_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, len_q, pb_q};
	assign m_axis_tuser  = {out_err_q, out_msk_q, out_fin_q, out_opc_q, st_q, pv_q};
	assign m_axis_tlast  = en_q;

endmodule

`default_nettype wire

/* design/wsd_checker.sv */
// Port-level checks for the websocket frame deframer result stream.
// Depends on wsd_pkg; bound to websocket_frame_deframer below.
`default_nettype none

module wsd_checker import wsd_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TU_ERR] |->
			!m_axis_tuser[TU_PV] && !m_axis_tuser[TU_START] && !m_axis_tlast)
		else $error("error result carries payload or frame marks");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[TU_PV] |-> m_axis_tdata[DATA_W-1:0] == '0)
		else $error("payload byte nonzero without payload_valid");

	a_start_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[TU_START] && m_axis_tuser[TU_PV]))
		else $error("frame_start on a payload byte");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && !m_axis_tuser[TU_PV] |->
			m_axis_tuser[TU_START])
		else $error("frame_end on a header byte without frame_start");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
